/* hw/rtl/grdfs_pkg.sv */
// Package for the graph reachability block.
// Holds the size constants, the request and state codes, the adjacency
// command struct and the lowest-set-bit encoder. Depends on nothing.
package grdfs_pkg;

   localparam int MAX_VERTICES = 16;
   localparam int VERTEX_W     = 4;
   localparam int IDX_W        = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int DEPTH_W      = $clog2(MAX_VERTICES + 1);

   typedef logic [MAX_VERTICES-1:0] row_type;
   typedef logic [IDX_W-1:0]        idx_type;
   typedef logic [DEPTH_W-1:0]      depth_type;

   typedef enum logic [1:0] {
      FUNC_ADD_EDGE = 2'd0,
      FUNC_CLEAR    = 2'd1,
      FUNC_QUERY    = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic    add;
      logic    clear;
      idx_type src;
      idx_type dst;
   } adj_cmd_type;

   function automatic idx_type first_set(input row_type v);
      idx_type r;
      r = '0;
      for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = IDX_W'(i);
         end
      end
      return r;
   endfunction

endpackage

/* hw/rtl/grdfs_adj.sv */
// Adjacency bit matrix of the graph reachability block.
// One row per tail vertex; edge set, clear-all and one row read port.
// Depends on grdfs_pkg.
module grdfs_adj (
   input  logic                   clock,
   input  logic                   reset,
   input  grdfs_pkg::adj_cmd_type cmd,
   input  grdfs_pkg::idx_type     rd_addr,
   output grdfs_pkg::row_type     rd_row
);

   grdfs_pkg::row_type rows_ff [grdfs_pkg::MAX_VERTICES];

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int i = 0; i < grdfs_pkg::MAX_VERTICES; i++) begin
            rows_ff[i] <= '0;
         end
      end else if (cmd.add) begin
         rows_ff[cmd.src] <= rows_ff[cmd.src] | (grdfs_pkg::row_type'(1) << cmd.dst);
      end
   end

   assign rd_row = rows_ff[rd_addr];

endmodule

/* hw/rtl/graph_reachability_dfs.sv */
// Top level of the graph reachability block.
// Runs a depth-first walk over the adjacency matrix in grdfs_adj.
// Depends on grdfs_pkg and grdfs_adj.
//
// A request is taken at a rising edge with start high and busy low. It
// carries req_func, req_src_vertex and req_dst_vertex. An add-edge request
// sets one bit of the adjacency matrix and a clear request empties it;
// neither gives a response. A query gives one response: rsp_valid is
// high for exactly one cycle with rsp_path_exists beside it. A query whose
// start equals its target answers in the cycle after the request.
// Otherwise the walk pops one stack entry per cycle in its pop state and
// pushes one newly found vertex per cycle in its scan state. The target is
// never pushed, and the response shows in the first cycle with busy low
// again. A new request may be taken in the cycle that shows a response.
// The receiver cannot stall, so no response is ever held back. Reset
// empties the graph and returns the block to idle.
module graph_reachability_dfs (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_func,
   input  logic [grdfs_pkg::VERTEX_W-1:0]   req_src_vertex,
   input  logic [grdfs_pkg::VERTEX_W-1:0]   req_dst_vertex,
   output logic                             rsp_valid,
   output logic                             rsp_path_exists
);

   grdfs_pkg::state_type   state_ff, state_in;
   grdfs_pkg::row_type     visited_ff, visited_in;
   grdfs_pkg::row_type     fresh_ff, fresh_in;
   grdfs_pkg::depth_type   depth_ff, depth_in;
   grdfs_pkg::idx_type     target_ff, target_in;
   grdfs_pkg::idx_type     stack_ff [grdfs_pkg::MAX_VERTICES];
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_found_ff, rsp_found_in;

   logic                   accept;
   logic                   in_range;
   grdfs_pkg::idx_type     src_idx;
   grdfs_pkg::idx_type     dst_idx;
   grdfs_pkg::depth_type   depth_dec;
   grdfs_pkg::idx_type     node;
   grdfs_pkg::row_type     row;
   grdfs_pkg::row_type     row_fresh;
   grdfs_pkg::idx_type     pick;
   grdfs_pkg::row_type     fresh_rest;
   logic                   push;
   grdfs_pkg::idx_type     push_addr;
   grdfs_pkg::idx_type     push_data;
   grdfs_pkg::adj_cmd_type adj_cmd;

   assign accept    = start && !busy;
   assign in_range  = (32'(req_src_vertex) < 32'(grdfs_pkg::MAX_VERTICES)) &&
                      (32'(req_dst_vertex) < 32'(grdfs_pkg::MAX_VERTICES));
   assign src_idx   = grdfs_pkg::IDX_W'(req_src_vertex);
   assign dst_idx   = grdfs_pkg::IDX_W'(req_dst_vertex);
   assign depth_dec = depth_ff - grdfs_pkg::DEPTH_W'(1);
   assign node      = stack_ff[depth_dec[grdfs_pkg::IDX_W-1:0]];
   assign row_fresh = row & ~visited_ff;
   assign pick      = grdfs_pkg::first_set(fresh_ff);
   assign fresh_rest = fresh_ff & (fresh_ff - grdfs_pkg::row_type'(1));

   grdfs_adj u_adj (
      .clock   (clock),
      .reset   (reset),
      .cmd     (adj_cmd),
      .rd_addr (node),
      .rd_row  (row)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         grdfs_pkg::ST_IDLE: begin
            if (accept && (req_func == grdfs_pkg::FUNC_QUERY) && in_range &&
                (src_idx != dst_idx)) begin
               state_in = grdfs_pkg::ST_POP;
            end
         end
         grdfs_pkg::ST_POP: begin
            if (depth_ff == '0) begin
               state_in = grdfs_pkg::ST_IDLE;
            end else if (row_fresh[target_ff]) begin
               state_in = grdfs_pkg::ST_IDLE;
            end else if (row_fresh != '0) begin
               state_in = grdfs_pkg::ST_SCAN;
            end
         end
         grdfs_pkg::ST_SCAN: begin
            if (fresh_rest == '0) begin
               state_in = grdfs_pkg::ST_POP;
            end
         end
         default: state_in = grdfs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      busy         = (state_ff != grdfs_pkg::ST_IDLE);
      visited_in   = visited_ff;
      fresh_in     = fresh_ff;
      depth_in     = depth_ff;
      target_in    = target_ff;
      rsp_valid_in = 1'b0;
      rsp_found_in = 1'b0;
      push         = 1'b0;
      push_addr    = depth_ff[grdfs_pkg::IDX_W-1:0];
      push_data    = pick;
      adj_cmd      = '{add: 1'b0, clear: 1'b0, src: src_idx, dst: dst_idx};
      unique case (state_ff)
         grdfs_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_func)
                  grdfs_pkg::FUNC_ADD_EDGE: adj_cmd.add = in_range;
                  grdfs_pkg::FUNC_CLEAR:    adj_cmd.clear = 1'b1;
                  grdfs_pkg::FUNC_QUERY: begin
                     if (!in_range) begin
                        rsp_valid_in = 1'b1;
                     end else if (src_idx == dst_idx) begin
                        rsp_valid_in = 1'b1;
                        rsp_found_in = 1'b1;
                        visited_in   = grdfs_pkg::row_type'(1) << src_idx;
                        depth_in     = '0;
                     end else begin
                        visited_in = grdfs_pkg::row_type'(1) << src_idx;
                        depth_in   = grdfs_pkg::DEPTH_W'(1);
                        target_in  = dst_idx;
                        push       = 1'b1;
                        push_addr  = '0;
                        push_data  = src_idx;
                     end
                  end
                  default: ;
               endcase
            end
         end
         grdfs_pkg::ST_POP: begin
            if (depth_ff == '0) begin
               rsp_valid_in = 1'b1;
            end else begin
               depth_in = depth_dec;
               fresh_in = row_fresh;
               if (row_fresh[target_ff]) begin
                  rsp_valid_in = 1'b1;
                  rsp_found_in = 1'b1;
                  visited_in   = visited_ff | (grdfs_pkg::row_type'(1) << target_ff);
               end
            end
         end
         grdfs_pkg::ST_SCAN: begin
            push       = 1'b1;
            visited_in = visited_ff | (grdfs_pkg::row_type'(1) << pick);
            depth_in   = depth_ff + grdfs_pkg::DEPTH_W'(1);
            fresh_in   = fresh_rest;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= grdfs_pkg::ST_IDLE;
         visited_ff   <= '0;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         visited_ff   <= visited_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fresh_ff     <= fresh_in;
      target_ff    <= target_in;
      rsp_found_ff <= rsp_found_in;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         stack_ff[push_addr] <= push_data;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_path_exists = rsp_found_ff;

   a_walk_end_responds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == grdfs_pkg::ST_IDLE && $past(state_ff) != grdfs_pkg::ST_IDLE)
      |-> rsp_valid_ff)
      else $error("walk ended without a response");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      32'(depth_ff) <= 32'(grdfs_pkg::MAX_VERTICES))
      else $error("stack depth beyond vertex count");

   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == grdfs_pkg::ST_SCAN) |-> (fresh_ff != '0))
      else $error("scan state with no vertex left to push");

   a_target_unvisited: assert property (@(posedge clock) disable iff (reset)
      (state_ff != grdfs_pkg::ST_IDLE) |-> !visited_ff[target_ff])
      else $error("target visited while the walk goes on");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the graph reachability block graph_reachability_dfs. Runs a
// table of directed requests and then random graph-building episodes. Path answers are checked
// against the table or a local depth-first predictor. Depends on grdfs_pkg and the block's RTL.
module testbench;
   import grdfs_pkg::*;

   localparam int CLOCK_HIGH      = 4;
   localparam int CLOCK_LOW       = 4;
   localparam int RESET_CYCLES    = 10;
   localparam int RANDOM_REQUESTS = 700;
   localparam int PAUSE_SPACING   = 150;
   localparam int DRAIN_CYCLES    = 2 * MAX_VERTICES + 8;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int MAX_REPORTS     = 10;
   localparam int PLAN_ROWS       = 24;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef logic [VERTEX_W-1:0] vertex_type;

   typedef struct packed {
      logic [1:0] func;
      vertex_type src;
      vertex_type dst;
      logic       checked;
      logic       answer;
   } plan_row_type;

   logic       clock           = 1'b0;
   logic       reset           = 1'b1;
   logic       start           = 1'b0;
   logic [1:0] req_func        = 2'd0;
   vertex_type req_src_vertex  = '0;
   vertex_type req_dst_vertex  = '0;
   logic       busy;
   logic       rsp_valid;
   logic       rsp_path_exists;

   row_type graph_edges [MAX_VERTICES] = '{default: '0};
   logic    expected_answers [$];
   logic    wanted_answer;
   int      failures      = 0;
   int      requests_sent = 0;
   int      burst_left    = 0;
   int      cycle_count   = 0;

   plan_row_type directed_plan [PLAN_ROWS] = '{
      '{FUNC_QUERY,    4'd0,  4'd15, 1'b1, 1'b0},
      '{FUNC_QUERY,    4'd15, 4'd0,  1'b1, 1'b0},
      '{FUNC_QUERY,    4'd7,  4'd7,  1'b1, 1'b1},
      '{FUNC_QUERY,    4'd0,  4'd0,  1'b1, 1'b1},
      '{FUNC_ADD_EDGE, 4'd0,  4'd15, 1'b0, 1'b0},
      '{FUNC_QUERY,    4'd0,  4'd15, 1'b1, 1'b1},
      '{FUNC_QUERY,    4'd15, 4'd0,  1'b1, 1'b0},
      '{FUNC_ADD_EDGE, 4'd0,  4'd15, 1'b0, 1'b0},
      '{FUNC_ADD_EDGE, 4'd15, 4'd15, 1'b0, 1'b0},
      '{FUNC_QUERY,    4'd15, 4'd0,  1'b1, 1'b0},
      '{FUNC_QUERY,    4'd15, 4'd15, 1'b1, 1'b1},
      '{FUNC_CLEAR,    4'd0,  4'd0,  1'b0, 1'b0},
      '{FUNC_QUERY,    4'd0,  4'd15, 1'b1, 1'b0},
      '{FUNC_UNUSED,   4'd0,  4'd15, 1'b0, 1'b0},
      '{FUNC_QUERY,    4'd0,  4'd15, 1'b1, 1'b0},
      '{FUNC_ADD_EDGE, 4'd3,  4'd9,  1'b0, 1'b0},
      '{FUNC_ADD_EDGE, 4'd9,  4'd12, 1'b0, 1'b0},
      '{FUNC_ADD_EDGE, 4'd12, 4'd3,  1'b0, 1'b0},
      '{FUNC_QUERY,    4'd3,  4'd12, 1'b0, 1'b0},
      '{FUNC_QUERY,    4'd12, 4'd9,  1'b0, 1'b0},
      '{FUNC_QUERY,    4'd9,  4'd0,  1'b0, 1'b0},
      '{FUNC_UNUSED,   4'd15, 4'd15, 1'b0, 1'b0},
      '{FUNC_CLEAR,    4'd15, 4'd15, 1'b0, 1'b0},
      '{FUNC_QUERY,    4'd3,  4'd12, 1'b1, 1'b0}
   };

   graph_reachability_dfs DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_src_vertex  (req_src_vertex),
      .req_dst_vertex  (req_dst_vertex),
      .rsp_valid       (rsp_valid),
      .rsp_path_exists (rsp_path_exists)
   );

   always begin
      #CLOCK_HIGH clock = 1'b1;
      #CLOCK_LOW  clock = 1'b0;
   end

   function automatic logic path_search(input idx_type from, input idx_type goal);
      row_type seen;
      row_type fresh;
      idx_type pending [MAX_VERTICES];
      idx_type node;
      int      depth;
      seen = '0;
      seen[from] = 1'b1;
      if (from == goal) begin
         return 1'b1;
      end
      pending[0] = from;
      depth = 1;
      while (depth > 0) begin
         depth--;
         node = pending[depth];
         fresh = graph_edges[node] & ~seen;
         for (int w = 0; w < MAX_VERTICES; w++) begin
            if (fresh[w]) begin
               if (idx_type'(w) == goal) begin
                  return 1'b1;
               end
               seen[w] = 1'b1;
               if (depth < MAX_VERTICES) begin
                  pending[depth] = idx_type'(w);
                  depth++;
               end
            end
         end
      end
      return 1'b0;
   endfunction

   function automatic bit predict_request(input logic [1:0] f, input vertex_type s,
                                          input vertex_type d, output logic answer);
      answer = 1'b0;
      case (f)
         FUNC_ADD_EDGE: begin
            graph_edges[s][d] = 1'b1;
         end
         FUNC_CLEAR: begin
            graph_edges = '{default: '0};
         end
         FUNC_QUERY: begin
            answer = path_search(s, d);
            return 1'b1;
         end
         default: begin
         end
      endcase
      return 1'b0;
   endfunction

   task automatic log_failure(input string msg);
      failures++;
      if (failures <= MAX_REPORTS) begin
         $display("%s", msg);
      end
   endtask

   task automatic idle_cycles(input int n);
      repeat (n) begin
         @(negedge clock);
         start          <= 1'b0;
         req_func       <= 2'($urandom);
         req_src_vertex <= vertex_type'($urandom);
         req_dst_vertex <= vertex_type'($urandom);
      end
   endtask

   task automatic wait_for_answers();
      while (expected_answers.size() != 0) begin
         idle_cycles(1);
      end
   endtask

   task automatic send_request(input logic [1:0] f, input vertex_type s, input vertex_type d,
                               input bit use_typed = 1'b0, input logic typed_answer = 1'b0);
      bit   has_answer;
      logic answer;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            idle_cycles($urandom_range(1, 12));
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      start          <= 1'b1;
      req_func       <= f;
      req_src_vertex <= s;
      req_dst_vertex <= d;
      do @(posedge clock); while (busy !== 1'b0);
      has_answer = predict_request(f, s, d, answer);
      if (has_answer) begin
         expected_answers.push_back(use_typed ? typed_answer : answer);
      end
      if (f != FUNC_UNUSED) begin
         requests_sent++;
      end
   endtask

   task automatic run_random_requests();
      vertex_type order [MAX_VERTICES];
      vertex_type swap_v;
      vertex_type hub;
      vertex_type target;
      vertex_type extra;
      int         base;
      int         next_pause;
      int         kind;
      int         count;
      int         j;
      base = requests_sent;
      next_pause = PAUSE_SPACING;
      while (requests_sent - base < RANDOM_REQUESTS) begin
         kind = $urandom_range(0, 9);
         if (kind <= 3) begin
            if ($urandom_range(0, 2) != 0) begin
               send_request(FUNC_CLEAR, vertex_type'($urandom), vertex_type'($urandom));
            end
            count = $urandom_range(0, 28);
            repeat (count) begin
               send_request(FUNC_ADD_EDGE, vertex_type'($urandom), vertex_type'($urandom));
            end
            count = $urandom_range(1, 6);
            repeat (count) begin
               hub = vertex_type'($urandom);
               target = ($urandom_range(0, 5) == 0) ? hub : vertex_type'($urandom);
               send_request(FUNC_QUERY, hub, target);
            end
         end else if (kind <= 5) begin
            for (int i = 0; i < MAX_VERTICES; i++) begin
               order[i] = vertex_type'(i);
            end
            for (int i = MAX_VERTICES - 1; i > 0; i--) begin
               j = $urandom_range(0, i);
               swap_v = order[i];
               order[i] = order[j];
               order[j] = swap_v;
            end
            send_request(FUNC_CLEAR, vertex_type'($urandom), vertex_type'($urandom));
            count = $urandom_range(1, MAX_VERTICES - 1);
            if ($urandom_range(0, 1) == 0) begin
               for (int i = 0; i < count; i++) begin
                  send_request(FUNC_ADD_EDGE, order[i], order[i + 1]);
               end
            end else begin
               for (int i = count - 1; i >= 0; i--) begin
                  send_request(FUNC_ADD_EDGE, order[i], order[i + 1]);
               end
            end
            repeat ($urandom_range(0, 3)) begin
               send_request(FUNC_ADD_EDGE, vertex_type'($urandom), vertex_type'($urandom));
            end
            send_request(FUNC_QUERY, order[0], order[count]);
            send_request(FUNC_QUERY, order[count], order[0]);
            send_request(FUNC_QUERY, order[$urandom_range(0, count)],
                         order[$urandom_range(0, MAX_VERTICES - 1)]);
         end else if (kind == 6) begin
            hub = vertex_type'($urandom);
            target = vertex_type'($urandom);
            if (target == hub) begin
               target = hub + 1'b1;
            end
            send_request(FUNC_CLEAR, vertex_type'($urandom), vertex_type'($urandom));
            for (int i = 0; i < MAX_VERTICES; i++) begin
               if (vertex_type'(i) != target) begin
                  send_request(FUNC_ADD_EDGE, hub, vertex_type'(i));
               end
            end
            send_request(FUNC_QUERY, hub, target);
            extra = vertex_type'($urandom);
            if (extra == target) begin
               extra = target + 1'b1;
            end
            send_request(FUNC_ADD_EDGE, extra, target);
            send_request(FUNC_QUERY, hub, target);
            send_request(FUNC_QUERY, target, hub);
         end else begin
            count = $urandom_range(1, 6);
            repeat (count) begin
               send_request(2'($urandom), vertex_type'($urandom), vertex_type'($urandom));
            end
         end
         if (requests_sent - base >= next_pause) begin
            wait_for_answers();
            next_pause += PAUSE_SPACING + $urandom_range(0, 50);
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid !== 1'b0) begin
         if (expected_answers.size() == 0) begin
            log_failure($sformatf("Unexpected response: path_exists=%b rsp_valid=%b",
                                  rsp_path_exists, rsp_valid));
         end else begin
            wanted_answer = expected_answers.pop_front();
            if (rsp_valid !== 1'b1 || rsp_path_exists !== wanted_answer) begin
               log_failure($sformatf("Mismatch: path_exists expected %b, actual %b (valid %b)",
                                     wanted_answer, rsp_path_exists, rsp_valid));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed_plan[i]) begin
         send_request(directed_plan[i].func, directed_plan[i].src, directed_plan[i].dst,
                      directed_plan[i].checked, directed_plan[i].answer);
      end
      run_random_requests();
      wait_for_answers();
      idle_cycles(DRAIN_CYCLES);
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/grdfs_pkg.sv
hw/rtl/grdfs_adj.sv
hw/rtl/graph_reachability_dfs.sv
tb/testbench.sv
